@@ rtl/tcw_pkg.sv @@
// tcw_pkg: shared types, codes and constants of the text console writer.
// No dependencies; every other rtl file imports it.
`default_nettype none

package tcw_pkg;

   // geometry defaults (80x25 text mode)
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // character and attribute codes
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] BLANK_CODE   = 8'h20;
   localparam logic [7:0] RESET_COLOUR = 8'h0F;

   // request kinds
   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // register file: byte address 4*index, index in paddr[CSR_AW-1:2]
   localparam int                CSR_AW         = 3;
   localparam logic [CSR_AW-3:0] CSR_IDX_COLOUR = '0;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_word_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
   } rsp_word_type;

   // classified command, front to back
   typedef enum logic [2:0] {
      OP_CHAR,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef struct packed {
      logic init_busy;
   } eng_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SCROLL,
      ST_READ
   } eng_state_type;

endpackage

`default_nettype wire

@@ rtl/tcw_front.sv @@
// tcw_front: accepts request words, classifies them into commands and
// holds them in a two-entry command queue. Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  tcw_pkg::req_word_type  req_word,
   input  tcw_pkg::eng_status_type eng_status,
   output tcw_pkg::cmd_head_type  cmd_head,
   input  logic                   cmd_pop
);
   import tcw_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    q_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cmd_new;
   logic       accept, pop_ok;

   // classify: out-of-range reads and unused kinds turn into no-ops
   always_comb begin
      cmd_new = '{op: OP_NOP, char_code: req_word.char_code,
                  read_row: req_word.read_row, read_col: req_word.read_col};
      case (req_word.kind)
         KIND_PUT: begin
            cmd_new.op = (req_word.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
         end
         KIND_CLEAR: begin
            cmd_new.op = OP_CLEAR;
         end
         KIND_READ: begin
            if (int'(req_word.read_row) < ROWS && int'(req_word.read_col) < COLUMNS)
               cmd_new.op = OP_READ;
         end
         default: begin
            cmd_new.op = OP_NOP;
         end
      endcase
   end

   assign full   = (count_ff == 2'd2) | eng_status.init_busy;
   assign accept = push & ~full;
   assign pop_ok = cmd_pop & (count_ff != 2'd0);

   always_comb begin
      count_in  = count_ff + {1'b0, accept} - {1'b0, pop_ok};
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
   end

   assign cmd_head.valid = (count_ff != 2'd0);
   assign cmd_head.cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         q_ff[wr_ptr_ff] <= cmd_new;
   end

endmodule

`default_nettype wire

@@ rtl/tcw_engine.sv @@
// tcw_engine: back end. Cell memory, cursor, row ring offset and the
// sequencer for writes, reads, scroll blanking and clear sweeps. Depends on tcw_pkg.
`default_nettype none

module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              text_colour,
   input  tcw_pkg::cmd_head_type   cmd_head,
   output logic                    cmd_pop,
   output logic                    rsp_push,
   output tcw_pkg::rsp_word_type   rsp_word,
   input  logic                    rsp_full,
   output tcw_pkg::eng_status_type eng_status
);
   import tcw_pkg::*;

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
   localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_SCROLL = AW'(COLUMNS - 1);
   localparam logic [RW:0]   ROWS_EXT    = (RW + 1)'(ROWS);

   eng_state_type state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] top_ff, top_in;     // physical row holding logical row 0
   logic [AW-1:0] sweep_ff, sweep_in;

   logic [15:0]   mem [CELLS];
   logic [15:0]   rd_data_ff;

   cmd_type       cmd;
   logic [RW-1:0] lrow, phys_row;
   logic [CW-1:0] lcol;
   logic [RW:0]   phys_sum;
   logic [AW-1:0] cell_addr, scroll_addr;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;

   assign cmd = cmd_head.cmd;

   // logical to physical cell address
   always_comb begin
      lrow      = (cmd.op == OP_READ) ? RW'(cmd.read_row) : row_ff;
      lcol      = (cmd.op == OP_READ) ? CW'(cmd.read_col) : col_ff;
      phys_sum  = {1'b0, lrow} + {1'b0, top_ff};
      phys_row  = (phys_sum >= ROWS_EXT) ? RW'(phys_sum - ROWS_EXT) : RW'(phys_sum);
      cell_addr   = AW'(phys_row) * AW'(COLUMNS) + AW'(lcol);
      scroll_addr = AW'(top_ff) * AW'(COLUMNS) + sweep_ff;
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      top_in   = top_ff;
      sweep_in = sweep_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_word = '{cell_char: '0, cell_attr: '0,
                   cursor_row: 5'(row_ff), cursor_col: 7'(col_ff)};
      mem_we   = 1'b0;
      mem_wa   = cell_addr;
      mem_wd   = {text_colour, cmd.char_code};
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = {(state_ff == ST_INIT) ? RESET_COLOUR : text_colour, BLANK_CODE};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            mem_we   = 1'b1;
            mem_wa   = scroll_addr;
            mem_wd   = {text_colour, BLANK_CODE};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_SCROLL) begin
               sweep_in = '0;
               top_in   = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_push           = 1'b1;
            rsp_word.cell_char = rd_data_ff[7:0];
            rsp_word.cell_attr = rd_data_ff[15:8];
            state_in           = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_head.valid && !rsp_full) begin
               cmd_pop  = 1'b1;
               rsp_push = 1'b1;
               case (cmd.op)
                  OP_CHAR, OP_NEWLINE: begin
                     mem_we = (cmd.op == OP_CHAR);
                     if (cmd.op == OP_CHAR && col_ff != LAST_COL) begin
                        col_in = col_ff + 1'b1;
                     end else begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           state_in = ST_SCROLL;
                           sweep_in = '0;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     top_in   = '0;
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_READ: begin
                     rsp_push = 1'b0;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
               rsp_word.cursor_row = 5'(row_in);
               rsp_word.cursor_col = 7'(col_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign eng_status.init_busy = (state_ff == ST_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         top_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         top_ff   <= top_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[cell_addr];
   end

   // a command is taken only with room for its result
   a_pop_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_head.valid && !rsp_full)
      else $error("command popped without result space");

   // an accepted read answers in the next cycle
   a_read_next: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.op == OP_READ) |=> (state_ff == ST_READ) && rsp_push)
      else $error("read result not pushed one cycle after issue");

   // finishing a scroll rotates the ring by one row
   a_scroll_rotates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL && sweep_ff == LAST_SCROLL) |=> top_ff != $past(top_ff))
      else $error("scroll ended without advancing the top row");

   // cursor stays on the bottom row while its blank line is written
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (row_ff == LAST_ROW) && (col_ff == '0))
      else $error("cursor moved during scroll");

endmodule

`default_nettype wire

@@ rtl/tcw_rsp_queue.sv @@
// tcw_rsp_queue: two-entry result queue in front of the rsp_ ports.
// Depends on tcw_pkg.
`default_nettype none

module tcw_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_push,
   input  tcw_pkg::rsp_word_type in_word,
   output logic                  in_full,
   output logic                  empty,
   input  logic                  pop,
   output tcw_pkg::rsp_word_type rsp_word
);
   import tcw_pkg::*;

   localparam int DEPTH = 2;

   rsp_word_type q_ff [DEPTH];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign in_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = in_push & ~in_full;
   assign do_pop   = pop & ~empty;
   assign count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   assign rsp_word = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_ff ^ do_push;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         q_ff[wr_ptr_ff] <= in_word;
   end

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// text_console_writer: top level of the text-mode console engine.
// Depends on tcw_pkg, tcw_front, tcw_engine, tcw_rsp_queue.
//
//   channel   ports                        handshake            word
//   --------  ---------------------------  -------------------  ----------------------
//   request   push, full, req_word         push & !full         kind/char/row/col
//   result    empty, pop, rsp_word         pop & !empty         cell char/attr, cursor
//   csr       psel..pready, paddr, pwdata  psel&penable&pwrite  text_colour at addr 0
//
// Put, newline, read-out-of-range and unused kinds retire one per cycle while the
//   engine is idle and the result queue has room; an in-range read also passes
//   ST_READ (registered memory read port). A put or newline that leaves the last row
//   then runs ST_SCROLL to blank the new bottom row cell by cell; rows themselves are
//   never copied, a ring offset rotates them. A clear item sweeps every cell.
// Reset: synchronous, active high. After reset ST_INIT blanks every cell
//   in RESET_COLOUR with full high; csr writes are taken meanwhile.
// Stalls: a two-word command queue and a two-word result queue decouple both sides.
`default_nettype none

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        push,
   output logic                        full,
   input  tcw_pkg::req_word_type       req_word,
   // result side
   output logic                        empty,
   input  logic                        pop,
   output tcw_pkg::rsp_word_type       rsp_word,
   // csr port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcw_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tcw_pkg::*;

   logic [7:0]     text_colour_ff, text_colour_in;
   logic           csr_write;
   logic           csr_hit;

   cmd_head_type   cmd_head;
   logic           cmd_pop;
   eng_status_type eng_status;
   logic           rsp_push, rsp_full;
   rsp_word_type   eng_word;

   // ---------------------------------------------------------------
   // csr: one register, no wait states
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_AW-1:2] == CSR_IDX_COLOUR);
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = csr_hit ? {24'b0, text_colour_ff} : '0;

   always_comb begin
      text_colour_in = text_colour_ff;
      if (csr_write && csr_hit)
         text_colour_in = pwdata[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_colour_ff <= RESET_COLOUR;
      end else begin
         text_colour_ff <= text_colour_in;
      end
   end

   // ---------------------------------------------------------------
   // front: classify request words, queue commands
   // ---------------------------------------------------------------
   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_word   (req_word),
      .eng_status (eng_status),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop)
   );

   // ---------------------------------------------------------------
   // back: cell memory, cursor and sequencer
   // ---------------------------------------------------------------
   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .text_colour (text_colour_ff),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rsp_push    (rsp_push),
      .rsp_word    (eng_word),
      .rsp_full    (rsp_full),
      .eng_status  (eng_status)
   );

   // ---------------------------------------------------------------
   // result words wait here until popped
   // ---------------------------------------------------------------
   tcw_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .in_push  (rsp_push),
      .in_word  (eng_word),
      .in_full  (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire
